// ===== hw/rtl/bol_pkg.sv =====
// Shared types, field widths and operation codes for the bounded ordered list.
package bol_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	localparam int MODE_W   = 4;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT    = 4'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK     = 4'd3;
	localparam logic [MODE_W-1:0] MODE_INSERT       = 4'd4;
	localparam logic [MODE_W-1:0] MODE_REMOVE_AT    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_REMOVE_VALUE = 4'd6;
	localparam logic [MODE_W-1:0] MODE_FIND         = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CLEAR        = 4'd8;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

	typedef enum logic [1:0] {
		SEL_HOLD,
		SEL_LEFT,
		SEL_RIGHT,
		SEL_VALUE
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      occupied;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/bol_cell.sv =====
// One storage cell of the list chain: holds a word and flags a match against the search word.
module bol_cell #(
	parameter int DATA_WIDTH = bol_pkg::DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  bol_pkg::cell_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic [DATA_WIDTH-1:0] right_word,
	input  logic [DATA_WIDTH-1:0] new_word,
	output logic [DATA_WIDTH-1:0] word,
	output logic                  match
);
	import bol_pkg::*;

	logic [DATA_WIDTH-1:0] word_q;
	logic                  match_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.sel)
			SEL_HOLD:  word_q <= word_q;
			SEL_LEFT:  word_q <= left_word;
			SEL_RIGHT: word_q <= right_word;
			SEL_VALUE: word_q <= new_word;
		endcase
		match_q <= ctrl.occupied && (word_q == new_word);
	end

	assign word  = word_q;
	assign match = match_q;

endmodule

// ===== hw/rtl/bol_prefix.sv =====
// Log-depth inclusive prefix OR over the match flags of the cell chain.
module bol_prefix #(
	parameter int WIDTH = bol_pkg::DEF_CAPACITY
) (
	input  logic [WIDTH-1:0] flags,
	output logic [WIDTH-1:0] prefix
);
	localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] level_q [LEVELS+1];

	assign level_q[0] = flags;

	for (genvar l = 0; l < LEVELS; l++) begin : g_level
		for (genvar i = 0; i < WIDTH; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign level_q[l+1][i] = level_q[l][i] | level_q[l][i-(1<<l)];
			end else begin : g_pass
				assign level_q[l+1][i] = level_q[l][i];
			end
		end
	end

	assign prefix = level_q[LEVELS];

endmodule

// ===== hw/rtl/bounded_ordered_list.sv =====
// Top level of the bounded ordered list: control, cell chain and result register.
// The list is a chain of CAPACITY cells, front at cell zero, where every cell
// either keeps its word or takes the word of its left or right neighbor or the
// input word, so pushes, pops, inserts and removals anywhere take effect on the
// list in a single update step. Each transaction passes through an accept step,
// a compare step in which every cell compares its word with the input word, an
// update step for the chain and the count, and a report step that reads the front
// and back words of the updated list into the result register once that register
// is free or being taken, which raises out_valid. One operation is in flight at a
// time; the next transaction is taken as soon as the previous result is loaded,
// even while that result still waits on out_ready. Cell contents start undefined
// and only occupied cells are read, so there is no clearing pass after reset.
module bounded_ordered_list #(
	parameter int CAPACITY   = bol_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = bol_pkg::DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bol_pkg::MODE_W-1:0]   mode,
	input  logic [bol_pkg::VALUE_W-1:0]  value,
	input  logic [bol_pkg::POS_W-1:0]    position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bol_pkg::STATUS_W-1:0] status,
	output logic [bol_pkg::VALUE_W-1:0]  value_out,
	output logic [bol_pkg::POS_W-1:0]    found_position,
	output logic [bol_pkg::COUNT_W-1:0]  entry_count,
	output logic [bol_pkg::VALUE_W-1:0]  front_word,
	output logic [bol_pkg::VALUE_W-1:0]  back_word
);
	import bol_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_MATCH  = 2'd1;
	localparam logic [1:0] S_APPLY  = 2'd2;
	localparam logic [1:0] S_REPORT = 2'd3;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [MODE_W-1:0]   mode_q;
	logic [VALUE_W-1:0]  value_q;
	logic [POS_W-1:0]    pos_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [VALUE_W-1:0]  res_popped_q;
	logic [POS_W-1:0]    res_found_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic [POS_W-1:0]    out_found_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [VALUE_W-1:0]  out_front_q;
	logic [VALUE_W-1:0]  out_back_q;

	logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
	cell_ctrl_t            cell_ctrl [CAPACITY];
	logic [CAPACITY-1:0]   match_vec;
	logic [CAPACITY-1:0]   match_pfx;
	logic [CAPACITY-1:0]   first_vec;

	logic [63:0]           value_ext;
	logic [DATA_WIDTH-1:0] value_dw;
	logic [DATA_WIDTH-1:0] front_c;
	logic [DATA_WIDTH-1:0] back_c;
	logic [63:0]           front_ext;
	logic [63:0]           back_ext;
	logic [31:0]           count_ext;

	logic                  full_c;
	logic                  empty_c;
	logic                  pos_ok_c;
	logic                  any_match_c;
	logic [POS_W-1:0]      found_c;
	logic [STATUS_W-1:0]   status_c;
	logic [VALUE_W-1:0]    popped_c;
	logic [POS_W-1:0]      found_pos_c;
	logic [CNT_W-1:0]      count_next_c;
	logic                  report_load;

	assign value_ext = 64'(value_q);
	assign value_dw  = value_ext[DATA_WIDTH-1:0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [31:0] IDX = i;
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		cell_sel_t             sel_c;

		if (i == 0) begin : g_first
			assign left_w = value_dw;
		end else begin : g_inner_l
			assign left_w = cell_word[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner_r
			assign right_w = cell_word[i+1];
		end

		always_comb begin
			sel_c = SEL_HOLD;
			if (state_q == S_APPLY && status_c == ST_OK) begin
				unique case (mode_q)
					MODE_PUSH_FRONT: sel_c = SEL_LEFT;
					MODE_PUSH_BACK: begin
						if (IDX == 32'(count_q)) sel_c = SEL_VALUE;
					end
					MODE_POP_FRONT: sel_c = SEL_RIGHT;
					MODE_INSERT: begin
						if (IDX > 32'(pos_q)) sel_c = SEL_LEFT;
						else if (IDX == 32'(pos_q)) sel_c = SEL_VALUE;
					end
					MODE_REMOVE_AT: begin
						if (IDX >= 32'(pos_q)) sel_c = SEL_RIGHT;
					end
					MODE_REMOVE_VALUE: begin
						if (match_pfx[i]) sel_c = SEL_RIGHT;
					end
					default: sel_c = SEL_HOLD;
				endcase
			end
		end

		assign cell_ctrl[i].sel      = sel_c;
		assign cell_ctrl[i].occupied = (IDX < 32'(count_q));

		if (i == 0) begin : g_first_m
			assign first_vec[i] = match_vec[i];
		end else begin : g_inner_m
			assign first_vec[i] = match_vec[i] & ~match_pfx[i-1];
		end

		bol_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[i]),
			.left_word (left_w),
			.right_word(right_w),
			.new_word  (value_dw),
			.word      (cell_word[i]),
			.match     (match_vec[i])
		);
	end

	bol_prefix #(
		.WIDTH(CAPACITY)
	) u_prefix (
		.flags (match_vec),
		.prefix(match_pfx)
	);

	always_comb begin
		logic [31:0] idx;
		front_c = (count_q != '0) ? cell_word[0] : '0;
		back_c  = '0;
		found_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			idx = 32'(i);
			if (idx + 32'd1 == 32'(count_q)) back_c = back_c | cell_word[i];
			if (first_vec[i]) found_c = found_c | idx[POS_W-1:0];
		end
	end

	assign front_ext = 64'(front_c);
	assign back_ext  = 64'(back_c);
	assign count_ext = 32'(count_q);

	assign full_c      = (count_ext >= 32'(CAPACITY));
	assign empty_c     = (count_q == '0);
	assign pos_ok_c    = (32'(pos_q) < count_ext);
	assign any_match_c = match_pfx[CAPACITY-1];

	always_comb begin
		status_c     = ST_OK;
		popped_c     = '0;
		found_pos_c  = '0;
		count_next_c = count_q;
		unique case (mode_q)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full_c) status_c = ST_FULL;
				else count_next_c = count_q + CNT_W'(1);
			end
			MODE_POP_FRONT: begin
				if (empty_c) begin
					status_c = ST_EMPTY;
				end else begin
					popped_c     = front_ext[VALUE_W-1:0];
					count_next_c = count_q - CNT_W'(1);
				end
			end
			MODE_POP_BACK: begin
				if (empty_c) begin
					status_c = ST_EMPTY;
				end else begin
					popped_c     = back_ext[VALUE_W-1:0];
					count_next_c = count_q - CNT_W'(1);
				end
			end
			MODE_INSERT: begin
				if (!pos_ok_c) status_c = ST_MISSING;
				else if (full_c) status_c = ST_FULL;
				else count_next_c = count_q + CNT_W'(1);
			end
			MODE_REMOVE_AT: begin
				if (!pos_ok_c) status_c = ST_MISSING;
				else count_next_c = count_q - CNT_W'(1);
			end
			MODE_REMOVE_VALUE: begin
				if (!any_match_c) status_c = ST_MISSING;
				else count_next_c = count_q - CNT_W'(1);
			end
			MODE_FIND: begin
				if (!any_match_c) status_c = ST_MISSING;
				else found_pos_c = found_c;
			end
			MODE_CLEAR: count_next_c = '0;
			default: status_c = ST_OK;
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign report_load = (state_q == S_REPORT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_MATCH;
				end
				S_MATCH: state_q <= S_APPLY;
				S_APPLY: begin
					count_q <= count_next_c;
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (report_load) state_q <= S_IDLE;
				end
			endcase
			if (report_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q  <= mode;
			value_q <= value;
			pos_q   <= position;
		end
		if (state_q == S_APPLY) begin
			res_status_q <= status_c;
			res_popped_q <= popped_c;
			res_found_q  <= found_pos_c;
		end
		if (report_load) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_popped_q;
			out_found_q  <= res_found_q;
			out_count_q  <= count_ext[COUNT_W-1:0];
			out_front_q  <= front_ext[VALUE_W-1:0];
			out_back_q   <= back_ext[VALUE_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign value_out      = out_value_q;
	assign found_position = out_found_q;
	assign entry_count    = out_count_q;
	assign front_word     = out_front_q;
	assign back_word      = out_back_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_ext <= 32'(CAPACITY))
		else $error("Word count exceeds capacity.");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_MATCH))
		else $error("Accepted transaction did not start the compare step.");

	a_result_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_REPORT))
		else $error("Result appeared without a report step.");

	a_count_only_in_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_APPLY) |=> $stable(count_q))
		else $error("Word count changed outside the update step.");

endmodule

// ===== dv/tb_bounded_ordered_list.sv =====
// Self-checking testbench for the bounded ordered list: random list operations against a shadow list.
`timescale 1ns / 1ps

module tb_bounded_ordered_list;
	import bol_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;
	localparam int PHASE_ITEMS = 463;
	localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = MODE_CLEAR + 4'd1;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LAST = 4'd15;
	localparam int POS_MAX = (1 << POS_W) - 1;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
	} list_op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value_out;
		logic [POS_W-1:0]    found_position;
		logic [COUNT_W-1:0]  entry_count;
		logic [VALUE_W-1:0]  front_word;
		logic [VALUE_W-1:0]  back_word;
	} list_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = '0;
	logic [VALUE_W-1:0] value = '0;
	logic [POS_W-1:0] position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0] value_out;
	logic [POS_W-1:0] found_position;
	logic [COUNT_W-1:0] entry_count;
	logic [VALUE_W-1:0] front_word;
	logic [VALUE_W-1:0] back_word;

	list_op_t op_queue[$];
	list_report_t pending_reports[$];
	logic [VALUE_W-1:0] shadow_words [CAPACITY];
	int shadow_count = 0;
	int error_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int sender_gaps [4] = '{0, 53, 0, 25};
	int recv_stalls [4] = '{0, 0, 53, 25};

	bounded_ordered_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.value_out(value_out),
		.found_position(found_position),
		.entry_count(entry_count),
		.front_word(front_word),
		.back_word(back_word)
	);

	function automatic void open_slot(int at, logic [VALUE_W-1:0] word);
		int k;
		for (k = shadow_count; k > at; k--) shadow_words[k] = shadow_words[k - 1];
		shadow_words[at] = word;
		shadow_count++;
	endfunction

	function automatic logic [VALUE_W-1:0] close_slot(int at);
		logic [VALUE_W-1:0] word;
		int k;
		word = shadow_words[at];
		for (k = at; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k + 1];
		shadow_count--;
		return word;
	endfunction

	function automatic list_report_t apply_list_op(list_op_t op);
		list_report_t r;
		int hit;
		int k;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		for (k = 0; k < shadow_count; k++) if (hit < 0 && shadow_words[k] == op.value) hit = k;
		case (op.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (shadow_count >= CAPACITY) r.status = ST_FULL;
				else open_slot(op.mode == MODE_PUSH_FRONT ? 0 : shadow_count, op.value);
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (shadow_count == 0) r.status = ST_EMPTY;
				else r.value_out = close_slot(op.mode == MODE_POP_FRONT ? 0 : shadow_count - 1);
			end
			MODE_INSERT: begin
				if (op.position >= shadow_count) r.status = ST_MISSING;
				else if (shadow_count >= CAPACITY) r.status = ST_FULL;
				else open_slot(op.position, op.value);
			end
			MODE_REMOVE_AT: begin
				if (op.position >= shadow_count) r.status = ST_MISSING;
				else void'(close_slot(op.position));
			end
			MODE_REMOVE_VALUE: begin
				if (hit < 0) r.status = ST_MISSING;
				else void'(close_slot(hit));
			end
			MODE_FIND: begin
				if (hit < 0) r.status = ST_MISSING;
				else r.found_position = hit[POS_W-1:0];
			end
			MODE_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		r.entry_count = shadow_count[COUNT_W-1:0];
		r.front_word = shadow_count != 0 ? shadow_words[0] : '0;
		r.back_word = shadow_count != 0 ? shadow_words[shadow_count - 1] : '0;
		return r;
	endfunction

	function automatic list_op_t op_of(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v,
			logic [POS_W-1:0] p);
		list_op_t op;
		op.mode = m;
		op.value = v;
		op.position = p;
		return op;
	endfunction

	function automatic void add_op(list_op_t op);
		op_queue.insert(op_queue.size(), op);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_word();
		if ($urandom_range(0, 99) >= 65) return $urandom;
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_0001;
			3: return 32'h8000_0000;
			4: return 32'h5A5A_5A5A;
			5: return 32'hA5A5_A5A5;
			6: return 32'h1234_5678;
			default: return 32'h0000_FFFF;
		endcase
	endfunction

	function automatic list_op_t random_op(bit growing);
		int roll;
		list_op_t op;
		roll = $urandom_range(0, 99);
		op.value = pick_word();
		op.position = POS_W'($urandom_range(0, POS_MAX));
		if (growing) begin
			if (roll < 25) op.mode = MODE_PUSH_BACK;
			else if (roll < 45) op.mode = MODE_PUSH_FRONT;
			else if (roll < 60) op.mode = MODE_INSERT;
			else if (roll < 68) op.mode = MODE_POP_FRONT;
			else if (roll < 75) op.mode = MODE_POP_BACK;
			else if (roll < 80) op.mode = MODE_REMOVE_AT;
			else if (roll < 87) op.mode = MODE_REMOVE_VALUE;
			else if (roll < 96) op.mode = MODE_FIND;
			else if (roll < 97) op.mode = MODE_CLEAR;
			else op.mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
		end else begin
			if (roll < 8) op.mode = MODE_PUSH_BACK;
			else if (roll < 14) op.mode = MODE_PUSH_FRONT;
			else if (roll < 18) op.mode = MODE_INSERT;
			else if (roll < 38) op.mode = MODE_POP_FRONT;
			else if (roll < 55) op.mode = MODE_POP_BACK;
			else if (roll < 68) op.mode = MODE_REMOVE_AT;
			else if (roll < 80) op.mode = MODE_REMOVE_VALUE;
			else if (roll < 93) op.mode = MODE_FIND;
			else if (roll < 95) op.mode = MODE_CLEAR;
			else op.mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
		end
		return op;
	endfunction

	task automatic wait_for_drain();
		while (op_queue.size() != 0 || in_valid || pending_reports.size() != 0) @(negedge clk);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		list_op_t next_op;
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= '0;
			value <= '0;
			position <= '0;
		end else begin
			if (in_valid && in_ready)
				pending_reports.insert(pending_reports.size(),
					apply_list_op(op_of(mode, value, position)));
			if ((!in_valid || in_ready) && op_queue.size() != 0 &&
					$urandom_range(0, 99) >= sender_idle_pct) begin
				next_op = op_queue[0];
				op_queue.delete(0);
				mode <= next_op.mode;
				value <= next_op.value;
				position <= next_op.position;
				in_valid <= 1'b1;
			end else if (in_valid && in_ready) begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		list_report_t got;
		list_report_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got.status = status;
				got.value_out = value_out;
				got.found_position = found_position;
				got.entry_count = entry_count;
				got.front_word = front_word;
				got.back_word = back_word;
				if (pending_reports.size() == 0) begin
					error_count++;
					$display("%0t: result with no transaction pending: status=%0d count=%0d",
						$time, got.status, got.entry_count);
				end else begin
					want = pending_reports[0];
					pending_reports.delete(0);
					if (got !== want) begin
						error_count++;
						$display("%0t: mismatch expected status=%0d value_out=%h found=%0d",
							$time, want.status, want.value_out, want.found_position,
							" count=%0d front=%h back=%h",
							want.entry_count, want.front_word, want.back_word);
						$display("%0t: mismatch actual   status=%0d value_out=%h found=%0d",
							$time, got.status, got.value_out, got.found_position,
							" count=%0d front=%h back=%h",
							got.entry_count, got.front_word, got.back_word);
					end
				end
			end
			out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	initial begin
		int p;
		int n;
		int k;
		bit growing;
		growing = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		add_op(op_of(MODE_POP_FRONT, 32'h0, 4'd0));
		add_op(op_of(MODE_INSERT, 32'h0, 4'd0));
		add_op(op_of(MODE_FIND, 32'h0, 4'd0));
		add_op(op_of(MODE_PUSH_BACK, 32'h0000_0000, 4'd0));
		add_op(op_of(MODE_PUSH_FRONT, 32'hFFFF_FFFF, 4'd15));
		for (k = 1; k <= CAPACITY - 2; k++)
			add_op(op_of(MODE_PUSH_BACK, k * 32'h1111_1111, k[POS_W-1:0]));
		add_op(op_of(MODE_PUSH_FRONT, 32'h0000_0001, 4'd0));
		add_op(op_of(MODE_INSERT, 32'h8000_0000, 4'd15));
		add_op(op_of(MODE_FIND, 32'h0000_0000, 4'd0));
		add_op(op_of(MODE_REMOVE_VALUE, 32'hDEAD_BEEF, 4'd0));
		add_op(op_of(MODE_REMOVE_AT, 32'h0, 4'd15));
		add_op(op_of(MODE_INSERT, 32'h7FFF_FFFF, 4'd14));
		add_op(op_of(MODE_REMOVE_VALUE, 32'h0000_0000, 4'd0));
		add_op(op_of(MODE_POP_BACK, 32'h0, 4'd0));
		add_op(op_of(MODE_UNUSED_LAST, 32'hFFFF_FFFF, 4'd15));
		add_op(op_of(MODE_CLEAR, 32'h0, 4'd0));
		wait_for_drain();

		for (p = 0; p < 4; p++) begin
			sender_idle_pct = sender_gaps[p];
			recv_stall_pct = recv_stalls[p];
			n = 0;
			while (n < PHASE_ITEMS) begin
				growing = ~growing;
				repeat ($urandom_range(15, 50)) begin
					add_op(random_op(growing));
					n++;
				end
			end
			wait_for_drain();
		end

		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_bounded_ordered_list passed");
		end else begin
			$display("tb_bounded_ordered_list failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_bounded_ordered_list failed");
		$finish;
	end

endmodule
